@@ design/kt_pkg.sv @@
// Package for the keyed table: default sizes, field widths, codes and state type.
package kt_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int KEY_SYMBOLS_DEF = 8;
  localparam int SYM_W           = 5;
  localparam int VALUE_W         = 32;
  localparam int TIME_W          = 40;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;

  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
  localparam logic [OP_W-1:0] OP_TRIM   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_TRIMCHK,
    S_DONE
  } state_t;

endpackage

@@ design/kt_cell.sv @@
// One table cell: holds an entry and takes its neighbor's entry when the ring advances.
module kt_cell #(
  parameter int KEY_W = kt_pkg::KEY_SYMBOLS_DEF * kt_pkg::SYM_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_in,
  input  logic [KEY_W-1:0]           key_in,
  input  logic [kt_pkg::VALUE_W-1:0] value_in,
  input  logic [kt_pkg::TIME_W-1:0]  used_in,
  output logic                       valid_out,
  output logic [KEY_W-1:0]           key_out,
  output logic [kt_pkg::VALUE_W-1:0] value_out,
  output logic [kt_pkg::TIME_W-1:0]  used_out
);
  import kt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_out   <= key_in;
      value_out <= value_in;
      used_out  <= used_in;
    end
  end

endmodule

@@ design/kt_ctrl.sv @@
// Head of the ring: sequencer, the one compare unit that every entry passes, and result register.
module kt_ctrl #(
  parameter int DEPTH       = kt_pkg::DEPTH_DEF,
  parameter int KEY_SYMBOLS = kt_pkg::KEY_SYMBOLS_DEF,
  parameter int KEY_W       = KEY_SYMBOLS * kt_pkg::SYM_W,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kt_pkg::OP_W-1:0]      in_op,
  input  logic [KEY_W-1:0]             in_key,
  input  logic [kt_pkg::VALUE_W-1:0]   in_value,
  input  logic [kt_pkg::TIME_W-1:0]    in_now,
  input  logic [CNT_W-1:0]             in_limit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kt_pkg::STATUS_W-1:0]  out_status,
  output logic [kt_pkg::VALUE_W-1:0]   out_found,
  output logic [CNT_W-1:0]             out_count,
  output logic                         shift_en,
  input  logic                         h_valid,
  input  logic [KEY_W-1:0]             h_key,
  input  logic [kt_pkg::VALUE_W-1:0]   h_value,
  input  logic [kt_pkg::TIME_W-1:0]    h_used,
  output logic                         w_valid,
  output logic [KEY_W-1:0]             w_key,
  output logic [kt_pkg::VALUE_W-1:0]   w_value,
  output logic [kt_pkg::TIME_W-1:0]    w_used
);
  import kt_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  state_t state, state_next;

  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  val;
  logic [TIME_W-1:0]   now;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    idx;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  found;
  logic                hit;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic                best_valid;
  logic [IDX_W-1:0]    best_idx;
  logic [TIME_W-1:0]   best_used;
  logic [KEY_W-1:0]    best_key;

  logic [KEY_W-1:0] canon;
  logic             alive;
  logic             match;
  logic             older;
  logic             last;
  logic             hit_now;
  logic             free_now;

  // Clear every symbol from the first end symbol on.
  always_comb begin
    alive = 1'b1;
    canon = '0;
    for (int i = 0; i < KEY_SYMBOLS; i++) begin
      if (in_key[KEY_W-1-SYM_W*i -: SYM_W] == '0) alive = 1'b0;
      canon[KEY_W-1-SYM_W*i -: SYM_W] = alive ? in_key[KEY_W-1-SYM_W*i -: SYM_W] : '0;
    end
  end

  assign match    = h_valid && (h_key == key);
  assign older    = h_valid && (!best_valid || (h_used < best_used) ||
                    ((h_used == best_used) && (h_key < best_key)));
  assign last     = (idx == IDX_LAST);
  assign hit_now  = hit || match;
  assign free_now = free_found || !h_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_GET:  state_next = (canon == '0) ? S_DONE : S_SCAN;
            OP_PUT:  state_next = (canon == '0 || in_value == '0) ? S_DONE : S_SCAN;
            OP_TRIM: state_next = S_TRIMCHK;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (last) begin
          if (op == OP_TRIM) begin
            state_next = S_APPLY;
          end else if (op == OP_PUT && !hit_now && count != CNT_W'(DEPTH) && free_now) begin
            state_next = S_APPLY;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_APPLY:   if (last) state_next = (op == OP_TRIM) ? S_TRIMCHK : S_DONE;
      S_TRIMCHK: state_next = (count > limit) ? S_SCAN : S_DONE;
      S_DONE:    if (!out_valid || out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    shift_en = (state inside {S_SCAN, S_APPLY});
    w_valid  = h_valid;
    w_key    = h_key;
    w_value  = h_value;
    w_used   = h_used;
    case (state)
      S_SCAN: begin
        if (op == OP_PUT && match) begin
          w_value = val;
          w_used  = now;
        end
      end
      S_APPLY: begin
        if (op == OP_PUT && idx == free_idx) begin
          w_valid = 1'b1;
          w_key   = key;
          w_value = val;
          w_used  = now;
        end else if (op == OP_TRIM && idx == best_idx) begin
          w_valid = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_APPLY && last) begin
        count <= (op == OP_PUT) ? count + 1'b1 : count - 1'b1;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op         <= in_op;
        key        <= canon;
        val        <= in_value;
        now        <= in_now;
        limit      <= in_limit;
        idx        <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        best_valid <= 1'b0;
        found      <= '0;
        status     <= (in_op == OP_GET && canon == '0) ? ST_MISS :
                      (in_op == OP_PUT && (canon == '0 || in_value == '0)) ? ST_REJECT :
                      ST_OK;
      end
      S_SCAN: begin
        idx <= last ? '0 : idx + 1'b1;
        if (match) begin
          hit <= 1'b1;
          if (op == OP_GET) found <= h_value;
        end
        if (!h_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        if (older) begin
          best_valid <= 1'b1;
          best_idx   <= idx;
          best_used  <= h_used;
          best_key   <= h_key;
        end
        if (last) begin
          if (op == OP_GET && !hit_now) status <= ST_MISS;
          if (op == OP_PUT && !hit_now && (count == CNT_W'(DEPTH) || !free_now)) begin
            status <= ST_FULL;
          end
        end
      end
      S_APPLY: begin
        idx        <= last ? '0 : idx + 1'b1;
        best_valid <= 1'b0;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_status <= status;
          out_found  <= found;
          out_count  <= count;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/keyed_table_with_oldest_eviction.sv @@
// Top level of the keyed table: ring of entry cells around one head controller.
// A rejected put, an empty-key get or an unused operation skips the ring; get, update or full
// takes one ring pass, an insert two, and trim a check plus two passes per removed entry.
// One transaction at a time, input ready again as the result appears; each ring pass moves
// every entry past one compare unit.
// Reset (rst, synchronous, active high) clears valid bits, entry count and output valid flag.
module keyed_table_with_oldest_eviction #(
  parameter int DEPTH       = kt_pkg::DEPTH_DEF,
  parameter int KEY_SYMBOLS = kt_pkg::KEY_SYMBOLS_DEF,
  parameter int KEY_W       = KEY_SYMBOLS * kt_pkg::SYM_W,
  parameter int CNT_W       = $clog2(DEPTH + 1),
  parameter int IN_W        = ((KEY_W + kt_pkg::VALUE_W + kt_pkg::TIME_W + CNT_W + 7) / 8) * 8,
  parameter int OUT_W       = ((kt_pkg::VALUE_W + CNT_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // key, value, now, limit (from bit 0 up), zero padded
  input  logic [IN_W-1:0]             s_tdata,
  // operation
  input  logic [kt_pkg::OP_W-1:0]     s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // found_value, entry_count (from bit 0 up), zero padded
  output logic [OUT_W-1:0]            m_tdata,
  // status
  output logic [kt_pkg::STATUS_W-1:0] m_tuser
);
  import kt_pkg::*;

  localparam int VAL_LO = KEY_W;
  localparam int NOW_LO = VAL_LO + VALUE_W;
  localparam int LIM_LO = NOW_LO + TIME_W;

  // Cell outputs; cell 0 sits at the head of the ring.
  logic               c_valid [DEPTH];
  logic [KEY_W-1:0]   c_key   [DEPTH];
  logic [VALUE_W-1:0] c_value [DEPTH];
  logic [TIME_W-1:0]  c_used  [DEPTH];

  // Entry written back by the head into the tail cell.
  logic               w_valid;
  logic [KEY_W-1:0]   w_key;
  logic [VALUE_W-1:0] w_value;
  logic [TIME_W-1:0]  w_used;
  logic               shift_en;

  logic [VALUE_W-1:0] res_found;
  logic [CNT_W-1:0]   res_count;

  kt_ctrl #(
    .DEPTH(DEPTH), .KEY_SYMBOLS(KEY_SYMBOLS), .KEY_W(KEY_W), .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
    .in_key(s_tdata[KEY_W-1:0]),
    .in_value(s_tdata[NOW_LO-1:VAL_LO]),
    .in_now(s_tdata[LIM_LO-1:NOW_LO]),
    .in_limit(s_tdata[LIM_LO+CNT_W-1:LIM_LO]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_status(m_tuser), .out_found(res_found), .out_count(res_count),
    .shift_en(shift_en),
    .h_valid(c_valid[0]), .h_key(c_key[0]), .h_value(c_value[0]), .h_used(c_used[0]),
    .w_valid(w_valid), .w_key(w_key), .w_value(w_value), .w_used(w_used)
  );

  // Rotate toward the head; the head feeds the tail, so a full pass restores slot order.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      kt_cell #(.KEY_W(KEY_W)) u_cell (
        .clk(clk), .rst(rst), .en(shift_en),
        .valid_in(w_valid), .key_in(w_key), .value_in(w_value), .used_in(w_used),
        .valid_out(c_valid[i]), .key_out(c_key[i]),
        .value_out(c_value[i]), .used_out(c_used[i])
      );
    end else begin : g_body
      kt_cell #(.KEY_W(KEY_W)) u_cell (
        .clk(clk), .rst(rst), .en(shift_en),
        .valid_in(c_valid[i+1]), .key_in(c_key[i+1]),
        .value_in(c_value[i+1]), .used_in(c_used[i+1]),
        .valid_out(c_valid[i]), .key_out(c_key[i]),
        .value_out(c_value[i]), .used_out(c_used[i])
      );
    end
  end

  // Pack the result; padding stays zero.
  always_comb begin
    m_tdata = '0;
    m_tdata[VALUE_W-1:0] = res_found;
    m_tdata[VALUE_W+CNT_W-1:VALUE_W] = res_count;
  end

endmodule

@@ design/kt_checker.sv @@
// Port checker for the keyed table, bound to the top level.
module kt_checker #(
  parameter int DEPTH = kt_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int OUT_W = ((kt_pkg::VALUE_W + CNT_W + 7) / 8) * 8
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [OUT_W-1:0]            m_tdata,
  input logic [kt_pkg::STATUS_W-1:0] m_tuser
);
  import kt_pkg::*;

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // One transaction in work at a time.
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[VALUE_W+CNT_W-1:VALUE_W] <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[VALUE_W-1:0] == '0)
    else $error("value returned on a failed transaction");

endmodule

bind keyed_table_with_oldest_eviction kt_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W), .OUT_W(OUT_W))
  u_kt_checker (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );
